// ===== hdl/hpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram percentile limits package
// Shared sizes, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package hpl_pkg;

  localparam int BINS       = 1024;
  localparam int COUNT_BITS = 20;

  localparam int PIXEL_W    = 10;
  localparam int PERMILLE_W = 10;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = PERMILLE_W;

  localparam int BIN_W  = $clog2(BINS);
  localparam int NUM_W  = $clog2(BINS + 1);
  localparam int PROD_W = COUNT_BITS + PERMILLE_W;
  localparam int ACC_W  = PROD_W + BIN_W;

  localparam int PERMILLE_SCALE = 1000;
  localparam int LOW_RESET      = 20;
  localparam int HIGH_RESET     = 980;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_PERMILLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PERMILLE = CFG_IDX_W'(1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic pix_accept;
    logic load_targets;
    logic init_scan;
    logic sweep;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
  } sts_t;

endpackage

// ===== hdl/hpl_if.sv =====
// ----------------------------------------------------------------------------
// Histogram percentile limits channels
// Pixel request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface hpl_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [hpl_pkg::PIXEL_W-1:0] pixel;
  logic                       last_pixel;

  modport source (output valid, pixel, last_pixel, input ready);
  modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface hpl_result_if;
  logic                       valid;
  logic                       ready;
  logic [hpl_pkg::LIMIT_W-1:0] low_limit;
  logic [hpl_pkg::LIMIT_W-1:0] high_limit;

  modport source (output valid, low_limit, high_limit, input ready);
  modport sink   (input valid, low_limit, high_limit, output ready);
endinterface

interface hpl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hpl_pkg::CFG_IDX_W-1:0]  index;
  logic [hpl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/hpl_datapath.sv =====
// ----------------------------------------------------------------------------
// Histogram percentile limits datapath
// Bin memory with read-modify-write counting, pixel total, configuration
// registers, cumulative scan with threshold tests and the result register.
// ----------------------------------------------------------------------------
module hpl_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hpl_pkg::cmd_t                  cmd_i,
  output hpl_pkg::sts_t                  sts_o,
  input  logic [hpl_pkg::PIXEL_W-1:0]    pixel_i,
  input  logic                           cfg_we_i,
  input  logic [hpl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [hpl_pkg::LIMIT_W-1:0]    low_limit_o,
  output logic [hpl_pkg::LIMIT_W-1:0]    high_limit_o
);

  logic [hpl_pkg::COUNT_BITS-1:0] mem [hpl_pkg::BINS];

  logic [hpl_pkg::PERMILLE_W-1:0] low_permille_q, high_permille_q;
  logic [hpl_pkg::COUNT_BITS-1:0] total_q, total_d;

  logic [hpl_pkg::BIN_W-1:0]      px_idx;
  logic                           p1_vld_q, p2_vld_q, fwd_vld_q;
  logic [hpl_pkg::BIN_W-1:0]      p1_idx_q, p2_idx_q, fwd_idx_q;
  logic [hpl_pkg::COUNT_BITS-1:0] fwd_data_q;
  logic [hpl_pkg::COUNT_BITS-1:0] rd_q;
  logic [hpl_pkg::COUNT_BITS-1:0] old_cnt, new_cnt;

  logic [hpl_pkg::BIN_W-1:0]      addr_q;
  logic [hpl_pkg::BIN_W-1:0]      rd_addr, wr_addr;
  logic                           wr_en;
  logic [hpl_pkg::COUNT_BITS-1:0] wr_data;

  logic                           s1_vld_q, s2_vld_q;
  logic [hpl_pkg::NUM_W-1:0]      s1_num_q, s2_num_q;
  logic [hpl_pkg::PROD_W-1:0]     prod_q;
  logic [hpl_pkg::PROD_W-1:0]     tl_q, th_q;
  logic [hpl_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic                           low_found_q, high_found_q;
  logic [hpl_pkg::NUM_W-1:0]      low_q, high_q;
  logic [hpl_pkg::LIMIT_W-1:0]    out_low_q, out_high_q;

  always_comb begin
    if (32'(pixel_i) >= 32'(hpl_pkg::BINS)) begin
      px_idx = hpl_pkg::BIN_W'(hpl_pkg::BINS - 1);
    end else begin
      px_idx = hpl_pkg::BIN_W'(pixel_i);
    end
  end

  // A write from the item just ahead lands on the same edge as this item's read.
  assign old_cnt = (fwd_vld_q && (fwd_idx_q == p2_idx_q)) ? fwd_data_q : rd_q;
  assign new_cnt = (old_cnt == hpl_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;

  assign rd_addr = cmd_i.sweep ? addr_q : p1_idx_q;
  assign wr_addr = cmd_i.sweep ? addr_q : p2_idx_q;
  assign wr_en   = cmd_i.sweep | p2_vld_q;
  assign wr_data = cmd_i.sweep ? '0 : new_cnt;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    total_d = total_q;
    if (cmd_i.init_scan) begin
      total_d = '0;
    end else if (cmd_i.pix_accept && (total_q != hpl_pkg::COUNT_MAX)) begin
      total_d = total_q + 1'b1;
    end
  end

  assign acc_d = acc_q + hpl_pkg::ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_permille_q  <= hpl_pkg::PERMILLE_W'(hpl_pkg::LOW_RESET);
      high_permille_q <= hpl_pkg::PERMILLE_W'(hpl_pkg::HIGH_RESET);
      total_q         <= '0;
      addr_q          <= '0;
      p1_vld_q        <= 1'b0;
      p2_vld_q        <= 1'b0;
      fwd_vld_q       <= 1'b0;
      s1_vld_q        <= 1'b0;
      s2_vld_q        <= 1'b0;
      low_found_q     <= 1'b0;
      high_found_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == hpl_pkg::REG_LOW_PERMILLE)) begin
        low_permille_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == hpl_pkg::REG_HIGH_PERMILLE)) begin
        high_permille_q <= cfg_data_i;
      end
      total_q   <= total_d;
      p1_vld_q  <= cmd_i.pix_accept;
      p2_vld_q  <= p1_vld_q;
      fwd_vld_q <= p2_vld_q;
      s1_vld_q  <= cmd_i.scan;
      s2_vld_q  <= s1_vld_q;
      if (cmd_i.sweep) begin
        addr_q <= addr_q + 1'b1;
      end
      if (cmd_i.init_scan) begin
        low_found_q  <= (tl_q == '0);
        high_found_q <= 1'b0;
      end else if (s2_vld_q) begin
        if (acc_d >= hpl_pkg::ACC_W'(tl_q)) begin
          low_found_q <= 1'b1;
        end
        if (acc_d >= hpl_pkg::ACC_W'(th_q)) begin
          high_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q   <= px_idx;
    p2_idx_q   <= p1_idx_q;
    fwd_idx_q  <= p2_idx_q;
    fwd_data_q <= new_cnt;
    s1_num_q   <= hpl_pkg::NUM_W'(addr_q) + 1'b1;
    s2_num_q   <= s1_num_q;
    prod_q     <= hpl_pkg::PROD_W'(rd_q) * hpl_pkg::PROD_W'(hpl_pkg::PERMILLE_SCALE);
    if (cmd_i.load_targets) begin
      tl_q <= hpl_pkg::PROD_W'(low_permille_q) * hpl_pkg::PROD_W'(total_q);
      th_q <= hpl_pkg::PROD_W'(high_permille_q) * hpl_pkg::PROD_W'(total_q);
    end
    if (cmd_i.init_scan) begin
      acc_q  <= '0;
      low_q  <= (tl_q == '0) ? '0 : hpl_pkg::NUM_W'(hpl_pkg::BINS);
      high_q <= hpl_pkg::NUM_W'(hpl_pkg::BINS);
    end else if (s2_vld_q) begin
      acc_q <= acc_d;
      if (!low_found_q && (acc_d >= hpl_pkg::ACC_W'(tl_q))) begin
        low_q <= s2_num_q;
      end
      if (!high_found_q && (acc_d >= hpl_pkg::ACC_W'(th_q))) begin
        high_q <= s2_num_q;
      end
    end
    if (cmd_i.load_out) begin
      out_low_q  <= hpl_pkg::LIMIT_W'(low_q);
      out_high_q <= hpl_pkg::LIMIT_W'(high_q);
    end
  end

  assign sts_o.addr_last = (addr_q == hpl_pkg::BIN_W'(hpl_pkg::BINS - 1));
  assign low_limit_o     = out_low_q;
  assign high_limit_o    = out_high_q;

endmodule

// ===== hdl/hpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Histogram percentile limits controller
// Sequences the clearing pass, pixel counting, pipeline drain, cumulative
// scan and result hand-over.
// ----------------------------------------------------------------------------
module hpl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pix_valid_i,
  input  logic          pix_last_i,
  output logic          pix_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  hpl_pkg::sts_t sts_i,
  output hpl_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_COUNT,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_SCAN,
    ST_TAIL1,
    ST_TAIL2,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign pix_ready_o = (state_q == ST_COUNT);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    cmd_o.pix_accept = pix_valid_i && pix_ready_o;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (cmd_o.pix_accept && pix_last_i) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        cmd_o.load_targets = 1'b1;
        state_d            = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        cmd_o.init_scan = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.sweep = 1'b1;
        cmd_o.scan  = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_TAIL1;
        end
      end
      ST_TAIL1: begin
        state_d = ST_TAIL2;
      end
      ST_TAIL2: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_COUNT;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/histogram_percentile_limits.sv =====
// ----------------------------------------------------------------------------
// Histogram percentile limits
// Counts pixels into a bin histogram and, on the last pixel of an image,
// gives the low and high gray limits at the configured percentiles.
// ----------------------------------------------------------------------------
// Pixels are taken at one per cycle while the block is counting; a pixel that
// equals its neighbour is forwarded around the bin memory's read-modify-write.
// Once the last pixel of an image is taken, ready stays low while the pipeline
// drains and the bin memory is scanned one bin a cycle, being cleared as it
// goes; the result is then loaded into the output register, and if the
// previous result is still waiting there the block holds until it is taken.
// After reset the block first clears the bin memory in a pass during which no
// pixel is taken; configuration writes are accepted at any time.
// ----------------------------------------------------------------------------
module histogram_percentile_limits (
  input  logic          clk_i,
  input  logic          rst_ni,
  hpl_pixel_if.sink     pixel_i,
  hpl_result_if.source  result_o,
  hpl_cfg_if.sink       cfg_i
);

  hpl_pkg::cmd_t cmd;
  hpl_pkg::sts_t sts;
  logic          pix_ready;
  logic          out_valid;

  assign cfg_i.ready    = 1'b1;
  assign pixel_i.ready  = pix_ready;
  assign result_o.valid = out_valid;

  hpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pixel_i.valid),
    .pix_last_i  (pixel_i.last_pixel),
    .pix_ready_o (pix_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hpl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_i      (pixel_i.pixel),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .low_limit_o  (result_o.low_limit),
    .high_limit_o (result_o.high_limit)
  );

endmodule
